[rtl/evtl_pkg.sv]
// Shared types, constants and arithmetic helpers of the encoder velocity tracking loop.
`timescale 1ns / 1ps

package evtl_pkg;

	// Field and datapath widths.
	localparam int CNT_W    = 32;
	localparam int DT_W     = 20;
	localparam int VAL_W    = 32;
	localparam int QUO_W    = 34;
	localparam int DIV_IN_W = 53;
	localparam int SAT_W    = 51;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_REV_PER_TICK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRACK_KP     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRACK_KI     = 2'd2;

	localparam logic [31:0] REV_PER_TICK_RESET = 32'd4194304;

	// Rounding and scaling constants.
	localparam logic [63:0] RND_Q_HALF   = 64'h0000_0000_0000_8000;
	localparam logic [20:0] US_PER_SEC   = 21'd1000000;
	localparam logic [19:0] RND_US_HALF  = 20'd500000;

	// Operand pairs of the shared multiplier.
	typedef enum logic [2:0] {
		MUL_CNT_RPT = 3'd0,
		MUL_S_DT    = 3'd1,
		MUL_ERR_KI  = 3'd2,
		MUL_TH_DT   = 3'd3,
		MUL_TL_DT   = 3'd4,
		MUL_ERR_KP  = 3'd5
	} mul_sel_t;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic     load_in;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     ld_pos;
		logic     div_start;
		logic     div_sel_i;
		logic     upd_e;
		logic     ld_err;
		logic     ld_t;
		logic     ld_acc;
		logic     upd_i;
		logic     ld_m;
		logic     upd_s;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic              clip;
		logic [VAL_W-1:0]  val;
	} sat_res_t;

	// Magnitude of a 32-bit two's complement value; the most negative value maps to 2^31.
	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

	// Give a magnitude the requested sign in the wide signed format.
	function automatic logic signed [SAT_W-1:0] apply_sign(input logic neg,
		input logic [47:0] m);
		logic signed [SAT_W-1:0] x;
		x = $signed({3'b000, m});
		return neg ? -x : x;
	endfunction

	// Clip a wide signed value to the 32-bit signed range and flag the clip.
	function automatic sat_res_t sat32(input logic signed [SAT_W-1:0] v);
		sat_res_t r;
		r.clip = !((&v[SAT_W-1:31]) || !(|v[SAT_W-1:31]));
		if (!r.clip) begin
			r.val = v[31:0];
		end else if (v[SAT_W-1]) begin
			r.val = 32'h8000_0000;
		end else begin
			r.val = 32'h7fff_ffff;
		end
		return r;
	endfunction

endpackage

[rtl/evtl_div.sv]
// Divide-by-one-million unit: reciprocal estimate followed by a small remainder correction.
`timescale 1ns / 1ps

module evtl_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [evtl_pkg::DIV_IN_W-1:0] dividend,
	output logic                          done,
	output logic [evtl_pkg::QUO_W-1:0]    quotient
);
	import evtl_pkg::*;

	// floor(2^51 / 10^6). Applied to the top 32 dividend bits and shifted down by 30 it
	// never overshoots the quotient and falls short of it by at most five.
	localparam logic [31:0] RECIP     = 32'd2251799813;
	localparam int          TOP_LSB   = DIV_IN_W - 32;
	localparam int          REM_W     = 24;
	localparam int          FIX_STEPS = 6;

	logic [DIV_IN_W-1:0] x_q;
	logic [63:0]         est_q;
	logic [QUO_W-1:0]    qe_q;
	logic [REM_W-1:0]    rem_q;
	logic [QUO_W-1:0]    quo_q;
	logic [2:0]          phase_q;
	logic                done_q;
	logic [QUO_W-1:0]    qe_d;
	logic [REM_W-1:0]    qm_lo;
	logic [2:0]          fix;

	// The remainder of the estimate is below 2^24, so only the low bits of the
	// estimate times one million are needed. The correction counts how many whole
	// millions are left in that remainder.
	always_comb begin
		qe_d  = est_q[63:64-QUO_W];
		qm_lo = qe_d[REM_W-1:0] * REM_W'(US_PER_SEC);
		fix   = '0;
		for (int k = 1; k <= FIX_STEPS; k++) begin
			if (rem_q >= REM_W'(k * int'(US_PER_SEC))) begin
				fix = fix + 3'd1;
			end
		end
	end

	// One phase bit walks through estimate, remainder and correction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			done_q  <= 1'b0;
		end else if (start) begin
			phase_q <= 3'b001;
			done_q  <= 1'b0;
		end else begin
			phase_q <= {phase_q[1:0], 1'b0};
			if (phase_q[2]) begin
				done_q <= 1'b1;
			end
		end
	end

	// Dividend capture and the three arithmetic steps.
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= dividend;
		end
		if (phase_q[0]) begin
			est_q <= x_q[DIV_IN_W-1:TOP_LSB] * RECIP;
		end
		if (phase_q[1]) begin
			qe_q  <= qe_d;
			rem_q <= x_q[REM_W-1:0] - qm_lo;
		end
		if (phase_q[2]) begin
			quo_q <= qe_q + QUO_W'(fix);
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[rtl/evtl_datapath.sv]
// Datapath: configuration registers, loop state, shared multiplier and divider, result register.
`timescale 1ns / 1ps

module evtl_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [evtl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [evtl_pkg::VAL_W-1:0]     cfg_data,
	input  logic [evtl_pkg::CNT_W-1:0]     in_count,
	input  logic [evtl_pkg::DT_W-1:0]      in_dt,
	input  evtl_pkg::cmd_t                 cmd,
	output logic                           div_done,
	output logic [evtl_pkg::VAL_W-1:0]     position_rev,
	output logic [evtl_pkg::VAL_W-1:0]     position_estimate,
	output logic [evtl_pkg::VAL_W-1:0]     speed_estimate,
	output logic                           saturated
);
	import evtl_pkg::*;

	// Configuration registers.
	logic [31:0] rpt_q;
	logic [31:0] kp_q;
	logic [31:0] ki_q;

	// Loop state.
	logic signed [31:0] e_q;
	logic signed [31:0] i_q;
	logic signed [31:0] s_q;

	// Per-item working registers.
	logic signed [31:0] cnt_q;
	logic [DT_W-1:0]    dt_q;
	logic signed [31:0] pos_q;
	logic signed [31:0] err_q;
	logic [47:0]        t_q;
	logic [67:0]        acc_q;
	logic [63:0]        prod_q;
	logic [47:0]        m_q;
	logic               clip_q;

	// Result register.
	logic [31:0] out_pos_q;
	logic [31:0] out_e_q;
	logic [31:0] out_s_q;
	logic        out_sat_q;

	logic [31:0]          mul_a;
	logic [31:0]          mul_b;
	logic [63:0]          rsum;
	logic [47:0]          rq;
	logic [67:0]          i_sum;
	logic [DIV_IN_W-1:0]  div_in;
	logic [QUO_W-1:0]     div_q;
	sat_res_t             pos_res;
	sat_res_t             e_res;
	sat_res_t             err_res;
	sat_res_t             i_res;
	sat_res_t             s_res;

	// Operand selection for the shared 32 x 32 multiplier.
	always_comb begin
		unique case (cmd.mul_sel)
			MUL_CNT_RPT: begin
				mul_a = mag32(cnt_q);
				mul_b = rpt_q;
			end
			MUL_S_DT: begin
				mul_a = mag32(s_q);
				mul_b = {12'd0, dt_q};
			end
			MUL_ERR_KI: begin
				mul_a = mag32(err_q);
				mul_b = ki_q;
			end
			MUL_TH_DT: begin
				mul_a = {8'd0, t_q[47:24]};
				mul_b = {12'd0, dt_q};
			end
			MUL_TL_DT: begin
				mul_a = {8'd0, t_q[23:0]};
				mul_b = {12'd0, dt_q};
			end
			MUL_ERR_KP: begin
				mul_a = mag32(err_q);
				mul_b = kp_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Q16.16 rounding of the registered product; products stay below 2^63.
	assign rsum = prod_q + RND_Q_HALF;
	assign rq   = rsum[63:16];

	// Integral increment dividend: high and low partial products plus half a second.
	// Anything at or above 2^53 saturates the integral, so it is clamped there.
	assign i_sum = acc_q + 68'(prod_q) + 68'(RND_US_HALF);

	always_comb begin
		if (cmd.div_sel_i) begin
			div_in = (|i_sum[67:DIV_IN_W]) ? '1 : i_sum[DIV_IN_W-1:0];
		end else begin
			div_in = prod_q[DIV_IN_W-1:0] + DIV_IN_W'(RND_US_HALF);
		end
	end

	evtl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_in),
		.done     (div_done),
		.quotient (div_q)
	);

	// Saturating updates, one per sequencer step.
	always_comb begin
		pos_res = sat32(apply_sign(cnt_q[31], rq));
		e_res   = sat32(SAT_W'(e_q) + apply_sign(s_q[31], 48'(div_q)));
		err_res = sat32(SAT_W'(pos_q) - SAT_W'(e_q));
		i_res   = sat32(SAT_W'(i_q) + apply_sign(err_q[31], 48'(div_q)));
		s_res   = sat32(apply_sign(err_q[31], m_q) + SAT_W'(i_q));
	end

	// Configuration writes and loop state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpt_q <= REV_PER_TICK_RESET;
			kp_q  <= '0;
			ki_q  <= '0;
			e_q   <= '0;
			i_q   <= '0;
			s_q   <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_REV_PER_TICK: rpt_q <= cfg_data;
					REG_TRACK_KP:     kp_q  <= cfg_data;
					REG_TRACK_KI:     ki_q  <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.upd_e) begin
				e_q <= e_res.val;
			end
			if (cmd.upd_i) begin
				i_q <= i_res.val;
			end
			if (cmd.upd_s) begin
				s_q <= s_res.val;
			end
		end
	end

	// Working registers of the item in flight.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cnt_q  <= in_count;
			dt_q   <= in_dt;
			clip_q <= 1'b0;
		end else if ((cmd.upd_e && e_res.clip) || (cmd.upd_i && i_res.clip) ||
			(cmd.upd_s && s_res.clip)) begin
			clip_q <= 1'b1;
		end
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.ld_pos) begin
			pos_q <= pos_res.val;
		end
		if (cmd.ld_err) begin
			err_q <= err_res.val;
		end
		if (cmd.ld_t) begin
			t_q <= rq;
		end
		if (cmd.ld_acc) begin
			acc_q <= {prod_q[43:0], 24'd0};
		end
		if (cmd.ld_m) begin
			m_q <= rq;
		end
		if (cmd.out_load) begin
			out_pos_q <= pos_q;
			out_e_q   <= e_q;
			out_s_q   <= s_q;
			out_sat_q <= clip_q;
		end
	end

	assign position_rev      = out_pos_q;
	assign position_estimate = out_e_q;
	assign speed_estimate    = out_s_q;
	assign saturated         = out_sat_q;

endmodule

[rtl/evtl_ctrl.sv]
// Sequencer: steps one item through the datapath and runs both stream handshakes.
`timescale 1ns / 1ps

module evtl_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  logic           div_done,
	output evtl_pkg::cmd_t cmd
);
	import evtl_pkg::*;

	typedef enum logic [17:0] {
		ST_IDLE     = 18'h00001,
		ST_MUL_P    = 18'h00002,
		ST_POS      = 18'h00004,
		ST_DIV_E_GO = 18'h00008,
		ST_DIV_E    = 18'h00010,
		ST_UPD_E    = 18'h00020,
		ST_ERR      = 18'h00040,
		ST_MUL_KI   = 18'h00080,
		ST_RND_T    = 18'h00100,
		ST_MUL_TH   = 18'h00200,
		ST_MUL_TL   = 18'h00400,
		ST_DIV_I_GO = 18'h00800,
		ST_DIV_I    = 18'h01000,
		ST_UPD_I    = 18'h02000,
		ST_MUL_KP   = 18'h04000,
		ST_RND_S    = 18'h08000,
		ST_UPD_S    = 18'h10000,
		ST_DONE     = 18'h20000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	// Next state and the commands issued in each state.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_MUL_P;
				end
			end
			ST_MUL_P: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_CNT_RPT;
				state_d     = ST_POS;
			end
			ST_POS: begin
				cmd.ld_pos  = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_S_DT;
				state_d     = ST_DIV_E_GO;
			end
			ST_DIV_E_GO: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV_E;
			end
			ST_DIV_E: begin
				if (div_done) begin
					state_d = ST_UPD_E;
				end
			end
			ST_UPD_E: begin
				cmd.upd_e = 1'b1;
				state_d   = ST_ERR;
			end
			ST_ERR: begin
				cmd.ld_err = 1'b1;
				state_d    = ST_MUL_KI;
			end
			ST_MUL_KI: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_ERR_KI;
				state_d     = ST_RND_T;
			end
			ST_RND_T: begin
				cmd.ld_t = 1'b1;
				state_d  = ST_MUL_TH;
			end
			ST_MUL_TH: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_TH_DT;
				state_d     = ST_MUL_TL;
			end
			ST_MUL_TL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_TL_DT;
				cmd.ld_acc  = 1'b1;
				state_d     = ST_DIV_I_GO;
			end
			ST_DIV_I_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel_i = 1'b1;
				state_d       = ST_DIV_I;
			end
			ST_DIV_I: begin
				if (div_done) begin
					state_d = ST_UPD_I;
				end
			end
			ST_UPD_I: begin
				cmd.upd_i = 1'b1;
				state_d   = ST_MUL_KP;
			end
			ST_MUL_KP: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_ERR_KP;
				state_d     = ST_RND_S;
			end
			ST_RND_S: begin
				cmd.ld_m = 1'b1;
				state_d  = ST_UPD_S;
			end
			ST_UPD_S: begin
				cmd.upd_s = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				// The result register must be empty or emptying this cycle.
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

[rtl/encoder_velocity_tracking_loop_core.sv]
// Top level of the encoder velocity tracking loop.
`timescale 1ns / 1ps

// Each input transfer carries a signed encoder count and the microseconds since the
// previous update; each one yields exactly one output transfer with the measured position,
// the tracked position estimate and the speed estimate (signed Q16.16), plus a flag set
// when the estimate, integral or speed clipped. An item is stepped through in full before
// the next input transfer is taken: the sequencer drives one shared 32 x 32 multiplier
// step by step and makes two passes through the divide-by-one-million unit, each pass a
// reciprocal estimate followed by a remainder correction. The result waits in an output
// register, so a new item is taken while the previous result is still unclaimed; the
// sequencer only stalls when it finishes an item while the earlier result is still
// waiting. Configuration writes go to the gain and scale registers and must only be
// made while no item is in flight; the loop state clears to zero on reset.
module encoder_velocity_tracking_loop_core (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration write port.
	input  logic                           cfg_we,
	input  logic [evtl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [evtl_pkg::VAL_W-1:0]     cfg_data,
	// Input stream.
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [55:0]                    s_axis_tdata,  // encoder_count[31:0], dt_us[51:32]
	// Output stream.
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [95:0]                    m_axis_tdata,  // position_rev[31:0],
	                                                      // position_estimate[63:32],
	                                                      // speed_estimate[95:64]
	output logic                           m_axis_tuser   // saturated
);
	import evtl_pkg::*;

	cmd_t        cmd;
	logic        div_done;
	logic [31:0] position_rev;
	logic [31:0] position_estimate;
	logic [31:0] speed_estimate;

	// Sequencer.
	evtl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.div_done  (div_done),
		.cmd       (cmd)
	);

	// Arithmetic and state.
	evtl_datapath u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_count          (s_axis_tdata[CNT_W-1:0]),
		.in_dt             (s_axis_tdata[CNT_W+DT_W-1:CNT_W]),
		.cmd               (cmd),
		.div_done          (div_done),
		.position_rev      (position_rev),
		.position_estimate (position_estimate),
		.speed_estimate    (speed_estimate),
		.saturated         (m_axis_tuser)
	);

	// Pack the result fields, lowest field first.
	assign m_axis_tdata = {speed_estimate, position_estimate, position_rev};

endmodule

[dv/evtl_checker.sv]
// Checker for the encoder velocity tracking loop: tracks configuration, predicts and compares results.
`timescale 1ns / 1ps

module evtl_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [evtl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [evtl_pkg::VAL_W-1:0]     cfg_data,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [55:0]                    s_axis_tdata,  // encoder_count[31:0], dt_us[51:32]
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [95:0]                    m_axis_tdata,  // position_rev[31:0],
	                                                      // position_estimate[63:32],
	                                                      // speed_estimate[95:64]
	input  logic                           m_axis_tuser,  // saturated
	output int                             mismatches,
	output int                             pending,
	output int                             results_checked,
	output int                             saturated_seen
);
	import evtl_pkg::*;

	localparam longint unsigned INC_CAP  = 64'd8589934592;
	localparam longint unsigned U64_MAX  = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam longint unsigned USEC     = 64'd1000000;

	typedef struct packed {
		logic [31:0] position_rev;
		logic [31:0] position_estimate;
		logic [31:0] speed_estimate;
		logic        saturated;
	} loop_out_t;

	// Shadow copy of the gain registers and the loop state.
	logic [31:0]        scale_rpt;
	logic [31:0]        gain_kp;
	logic [31:0]        gain_ki;
	logic signed [31:0] est_pos;
	logic signed [31:0] integ;
	logic signed [31:0] est_spd;

	// Results predicted for accepted items, oldest first.
	loop_out_t due_q[$];

	function automatic longint unsigned round_q16(input longint unsigned m);
		return (m + 64'd32768) >> 16;
	endfunction

	function automatic longint unsigned round_us(input longint unsigned m);
		return (m + 64'd500000) / USEC;
	endfunction

	function automatic longint unsigned magnitude(input longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint with_sign(input bit neg, input longint unsigned m);
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647) begin
			return 32'sh7fff_ffff;
		end
		if (v < -64'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	// One update of the tracking loop: measured position, estimate, integral and speed.
	task automatic advance_loop(input logic signed [31:0] count, input logic [19:0] dt,
		output loop_out_t r);
		longint unsigned    m;
		longint unsigned    t;
		longint unsigned    inc;
		longint unsigned    dtw;
		longint             sum;
		logic signed [31:0] pos;
		logic signed [31:0] err;
		bit                 hit;
		hit = 1'b0;
		dtw = {44'd0, dt};

		m = round_q16(magnitude(count) * {32'd0, scale_rpt});
		pos = clamp32(with_sign(count < 0, m));

		m = round_us(magnitude(est_spd) * dtw);
		sum = longint'(est_pos) + with_sign(est_spd < 0, m);
		est_pos = clamp32(sum);
		hit |= (longint'(est_pos) != sum);

		err = clamp32(longint'(pos) - longint'(est_pos));

		// The integral step is clipped to 2^33 when the product would not fit in 64 bits or the step exceeds that cap.
		t = round_q16(magnitude(err) * {32'd0, gain_ki});
		if (dt != 20'd0 && t > (U64_MAX - USEC) / dtw) begin
			inc = INC_CAP;
		end else begin
			inc = round_us(t * dtw);
			if (inc > INC_CAP) begin
				inc = INC_CAP;
			end
		end
		sum = longint'(integ) + with_sign(err < 0, inc);
		integ = clamp32(sum);
		hit |= (longint'(integ) != sum);

		m = round_q16(magnitude(err) * {32'd0, gain_kp});
		sum = with_sign(err < 0, m) + longint'(integ);
		est_spd = clamp32(sum);
		hit |= (longint'(est_spd) != sum);

		r.position_rev      = pos;
		r.position_estimate = est_pos;
		r.speed_estimate    = est_spd;
		r.saturated         = hit;
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	// Follow register writes and both stream channels.
	always @(posedge clk or negedge arst_n) begin
		loop_out_t want;
		loop_out_t fresh;
		if (!arst_n) begin
			scale_rpt       = REV_PER_TICK_RESET;
			gain_kp         = '0;
			gain_ki         = '0;
			est_pos         = '0;
			integ           = '0;
			est_spd         = '0;
			mismatches      = 0;
			results_checked = 0;
			saturated_seen  = 0;
			due_q.delete();
		end else begin
			// An output transfer is always older than an input accepted at the same edge.
			if (m_axis_tvalid && m_axis_tready) begin
				if (due_q.size() == 0) begin
					mismatches++;
					$display("%0t: result with none outstanding, expected nothing, actual %h %b",
						$time, m_axis_tdata, m_axis_tuser);
				end else begin
					want = due_q.pop_front();
					results_checked++;
					if (m_axis_tuser) begin
						saturated_seen++;
					end
					compare_field("position_rev", want.position_rev, m_axis_tdata[31:0]);
					compare_field("position_estimate", want.position_estimate,
						m_axis_tdata[63:32]);
					compare_field("speed_estimate", want.speed_estimate, m_axis_tdata[95:64]);
					compare_field("saturated", {31'd0, want.saturated}, {31'd0, m_axis_tuser});
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_REV_PER_TICK: scale_rpt = cfg_data;
					REG_TRACK_KP:     gain_kp = cfg_data;
					REG_TRACK_KI:     gain_ki = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				advance_loop(s_axis_tdata[31:0], s_axis_tdata[51:32], fresh);
				due_q.push_back(fresh);
			end
		end
		pending = due_q.size();
	end

endmodule

[dv/testbench.sv]
// Top of the encoder velocity tracking loop testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
	import evtl_pkg::*;

	localparam int                   CYCLE_LIMIT  = 1000000;
	localparam int                   DRAIN_CYCLES = 60;
	localparam int                   HOLD_CYCLES  = 800;
	localparam int                   HOLD_AFTER   = 400;
	localparam int                   RAND_PHASES  = 7;
	localparam int                   PHASE_ITEMS  = 268;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 2'd3;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [VAL_W-1:0]     cfg_data;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [55:0]          s_axis_tdata;   // encoder_count[31:0], dt_us[51:32]
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [95:0]          m_axis_tdata;   // position_rev[31:0], position_estimate[63:32],
	                                      // speed_estimate[95:64]
	logic                 m_axis_tuser;   // saturated

	int mismatches;
	int pending;
	int results_checked;
	int saturated_seen;
	int items_sent;
	int settings_used;
	int burst_left;

	encoder_velocity_tracking_loop_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	evtl_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tuser    (m_axis_tuser),
		.mismatches      (mismatches),
		.pending         (pending),
		.results_checked (results_checked),
		.saturated_seen  (saturated_seen)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	// Run limit.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb: failure");
		$finish;
	end

	// Output side: stall patterns that change at random, plus one long hold-off
	// that lets the block fill up and push back on its input.
	initial begin
		int  mode;
		int  span;
		bit  held;
		held = 1'b0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && items_sent >= HOLD_AFTER) begin
				held = 1'b1;
				repeat (HOLD_CYCLES) begin
					@(negedge clk);
					m_axis_tready <= 1'b0;
				end
			end
			mode = $urandom_range(0, 3);
			span = $urandom_range(5, 80);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					2: m_axis_tready <= ($urandom_range(0, 7) == 0);
					default: m_axis_tready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// Register write, one cycle of write enable.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_gains(input logic [31:0] rpt, input logic [31:0] kp,
		input logic [31:0] ki);
		write_reg(REG_REV_PER_TICK, rpt);
		write_reg(REG_TRACK_KP, kp);
		write_reg(REG_TRACK_KI, ki);
		settings_used++;
	endtask

	// Offer one item, wait for its transfer, then maybe open a gap before the next.
	task automatic send_item(input logic [31:0] count, input logic [19:0] dt);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'd0, dt, count};
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 40);
			gap = $urandom_range(0, 20);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	// Stop offering and let every outstanding result come back before the next phase.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic logic [31:0] pick_reg();
		case ($urandom_range(0, 4))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(1, 100) << 16;
			3: return $urandom_range(0, 65535);
			default: return $urandom;
		endcase
	endfunction

	// Stimulus and verdict.
	initial begin
		int          enc_pos;
		int          rate;
		logic [19:0] dt;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		items_sent = 0;
		settings_used = 0;
		burst_left = 0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Default gains; a write to the unused index must change nothing.
		write_reg(REG_UNUSED, 32'hDEAD_BEEF);
		send_item(32'd0, 20'd0);
		send_item(32'h7FFF_FFFF, 20'd1000);
		send_item(32'h8000_0000, 20'hFFFFF);
		send_item(32'hFFFF_FFFF, 20'd1);
		send_item(32'd1024, 20'd500);
		drain();

		// All registers at their maximum: clipped position, error, integral and speed,
		// an integral step too large for 64 bits, and updates with zero elapsed time.
		set_gains(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(32'h7FFF_FFFF, 20'hFFFFF);
		send_item(32'h8000_0000, 20'hFFFFF);
		send_item(32'd0, 20'd0);
		send_item(32'd12345, 20'd0);
		send_item(32'h8000_0000, 20'd1000);
		send_item(32'h7FFF_FFFF, 20'd1);
		send_item(32'd0, 20'hFFFFF);
		drain();

		// Realistic gains on a steady ramp.
		set_gains(32'h0040_0000, 32'd40 << 16, 32'd400 << 16);
		for (int i = 1; i <= 8; i++) begin
			send_item(i * 300, 20'd1000);
		end
		send_item(32'd2400, 20'd0);
		drain();

		// Random phases: mostly a smoothly moving encoder, with some noise items.
		enc_pos = 0;
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0: set_gains(32'h0040_0000, 32'd20 << 16, 32'd100 << 16);
				1: set_gains(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
				2: set_gains(32'd0, 32'd0, 32'd0);
				default: set_gains(pick_reg(), pick_reg(), pick_reg());
			endcase
			rate = $urandom_range(0, 10000) - 5000;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				case ($urandom_range(0, 9))
					0: send_item($urandom, 20'($urandom_range(0, 20'hFFFFF)));
					1: send_item(enc_pos, 20'd0);
					default: begin
						if ($urandom_range(0, 15) == 0) begin
							rate = $urandom_range(0, 10000) - 5000;
						end
						dt = 20'($urandom_range(200, 5000));
						enc_pos += rate * int'(dt) / 1000;
						send_item(enc_pos, dt);
					end
				endcase
			end
			drain();
		end

		$display("Run covered %0d input items under %0d gain settings, zero and full-scale among them.",
			items_sent, settings_used + 1);
		$display("%0d results compared, %0d of them with a clipped state value.",
			results_checked, saturated_seen);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
